FILE: sv/puf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
package puf_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 16;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_HAS_ALPHA = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FILT_NONE = 3'd0,
		FILT_SUB = 3'd1,
		FILT_UP = 3'd2,
		FILT_AVG = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	typedef struct packed {
		logic [7:0] sample;
		logic [1:0] chan;
		filter_t filter;
		logic bad;
		logic row_first;
		logic top_row;
		logic row_end;
		logic img_end;
	} item_flags_t;

endpackage

FILE: sv/puf_if.sv
// Stream interfaces for the input bytes and the reconstructed output bytes.
interface puf_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface puf_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_in_row;
	logic last_in_image;
	logic bad_filter;

	modport source (output valid, output out_byte, output last_in_row,
		output last_in_image, output bad_filter, input ready);
	modport sink (input valid, input out_byte, input last_in_row,
		input last_in_image, input bad_filter, output ready);
endinterface

FILE: sv/puf_front.sv
// Front end: configuration registers, row and byte tracking, item classification.
module puf_front #(
	parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF,
	parameter int IDX_W = $clog2(MAX_WIDTH * 4)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [puf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [puf_pkg::CFG_DATA_W-1:0] cfg_data,
	puf_in_if.sink in_stream,
	input logic q_full,
	output logic q_push,
	output logic [IDX_W-1:0] q_idx,
	output puf_pkg::item_flags_t q_flags
);
	import puf_pkg::*;

	localparam int RL_W = $clog2(MAX_WIDTH * 4 + 1);
	localparam int CW = (RL_W > WIDTH_W) ? RL_W : WIDTH_W;

	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic alpha_q;

	logic expect_filter_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0] ch3_q;
	logic [HEIGHT_W-1:0] row_q;
	filter_t filter_q;
	logic bad_q;

	logic fire;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] row_len;
	logic [HEIGHT_W-1:0] h_last;
	logic row_end;
	logic img_end;
	logic [1:0] chan;
	logic type_bad;

	assign in_stream.ready = !q_full;
	assign fire = in_stream.valid && !q_full;
	assign type_bad = in_stream.in_byte > 8'(FILT_PAETH);

	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (CW'(width_q) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		row_len = alpha_q ? (w_eff << 2) : ((w_eff << 1) + w_eff);
		h_last = (height_q == '0) ? '0 : height_q - HEIGHT_W'(1);
		row_end = (CW'(idx_q) + CW'(1)) >= row_len;
		img_end = row_end && (row_q >= h_last);
		chan = alpha_q ? idx_q[1:0] : ch3_q;
	end

	assign q_push = fire && !expect_filter_q;
	assign q_idx = idx_q;

	always_comb begin
		q_flags.sample = in_stream.in_byte;
		q_flags.chan = chan;
		q_flags.filter = filter_q;
		q_flags.bad = bad_q;
		q_flags.row_first = idx_q == '0;
		q_flags.top_row = row_q == '0;
		q_flags.row_end = row_end;
		q_flags.img_end = img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
			alpha_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[WIDTH_W-1:0];
				end
				CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_W-1:0];
				end
				CFG_HAS_ALPHA: begin
					alpha_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_filter_q <= 1'b1;
			idx_q <= '0;
			ch3_q <= '0;
			row_q <= '0;
			filter_q <= FILT_NONE;
			bad_q <= 1'b0;
		end else if (fire) begin
			if (expect_filter_q) begin
				bad_q <= type_bad;
				filter_q <= type_bad ? FILT_NONE : filter_t'(in_stream.in_byte[2:0]);
				expect_filter_q <= 1'b0;
				idx_q <= '0;
				ch3_q <= '0;
			end else if (row_end) begin
				expect_filter_q <= 1'b1;
				row_q <= img_end ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				ch3_q <= (ch3_q == 2'd2) ? 2'd0 : ch3_q + 2'd1;
			end
		end
	end

endmodule

FILE: sv/puf_queue.sv
// Small first-in first-out queue between the front end and the back end.
module puf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = puf_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [DATA_W-1:0] din,
	output logic full,
	input logic pop,
	output logic [DATA_W-1:0] dout,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/puf_back.sv
// Back end: prior-row memory, predictor selection, reconstruction and output register.
module puf_back #(
	parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF,
	parameter int IDX_W = $clog2(MAX_WIDTH * 4)
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input logic [IDX_W-1:0] q_idx,
	input puf_pkg::item_flags_t q_flags,
	output logic q_pop,
	puf_out_if.source out_stream
);
	import puf_pkg::*;

	localparam int STORE_DEPTH = MAX_WIDTH * 4;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] p;
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		p = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		pa = p - $signed({3'b000, a});
		pb = p - $signed({3'b000, b});
		pc = p - $signed({3'b000, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end
		return c;
	endfunction

	logic [7:0] store_mem [STORE_DEPTH];

	logic valid_s1;
	logic [IDX_W-1:0] idx_s1;
	item_flags_t flags_s1;
	logic [7:0] above_s1;

	logic [7:0] left_q [4];
	logic [7:0] upleft_q [4];

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_row_q;
	logic last_image_q;
	logic bad_q;

	logic advance;
	logic [7:0] pa_left;
	logic [7:0] pb_above;
	logic [7:0] pc_upleft;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] res;

	assign advance = valid_s1 && (!out_valid_q || out_stream.ready);
	assign q_pop = !q_empty && (!valid_s1 || advance);

	always_comb begin
		pa_left = flags_s1.row_first ? 8'd0 : left_q[flags_s1.chan];
		pc_upleft = flags_s1.row_first ? 8'd0 : upleft_q[flags_s1.chan];
		pb_above = flags_s1.top_row ? 8'd0 : above_s1;
		avg_sum = {1'b0, pa_left} + {1'b0, pb_above};
		case (flags_s1.filter)
			FILT_SUB: pred = pa_left;
			FILT_UP: pred = pb_above;
			FILT_AVG: pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth_pick(pa_left, pb_above, pc_upleft);
			default: pred = 8'd0;
		endcase
		res = flags_s1.sample + pred;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			store_mem[idx_s1] <= res;
		end
		if (q_pop) begin
			above_s1 <= store_mem[q_idx];
			idx_s1 <= q_idx;
			flags_s1 <= q_flags;
		end
		if (advance) begin
			out_byte_q <= res;
			last_row_q <= flags_s1.row_end;
			last_image_q <= flags_s1.img_end;
			bad_q <= flags_s1.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				left_q[k] <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				for (int k = 0; k < 4; k++) begin
					if (2'(k) == flags_s1.chan) begin
						left_q[k] <= res;
						upleft_q[k] <= pb_above;
					end else if (flags_s1.row_first) begin
						left_q[k] <= 8'd0;
						upleft_q[k] <= 8'd0;
					end
				end
			end
		end
	end

	assign out_stream.valid = out_valid_q;
	assign out_stream.out_byte = out_byte_q;
	assign out_stream.last_in_row = last_row_q;
	assign out_stream.last_in_image = last_image_q;
	assign out_stream.bad_filter = bad_q;

endmodule

FILE: sv/png_scanline_unfilter_core.sv
// Top level of the PNG scanline unfilter for 8-bit RGB and RGBA images.
//
// Channel      Direction  Payload                                           Accepted when
// in_stream    in         in_byte                                           valid && ready
// out_stream   out        out_byte, last_in_row, last_in_image, bad_filter  valid && ready
// cfg          in         cfg_index, cfg_data                               cfg_we
//
// The block takes one byte per cycle unless the queue is full; a filter byte is taken but
// gives no output. A data byte goes through the queue, the back end's stage register and
// the output register, and leaves that register once the output is ready.
// The prior-row memory has one read and one write port: an item reads it on entering the
// back end and writes it on leaving; one byte per cycle is sustained unless output stalls.
// Reset clears all control state; the prior-row memory needs no clearing pass.
// A stalled output fills the four-entry queue, after which the input ready falls.
module png_scanline_unfilter_core #(
	parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [puf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [puf_pkg::CFG_DATA_W-1:0] cfg_data,
	puf_in_if.sink in_stream,
	puf_out_if.source out_stream
);
	import puf_pkg::*;

	localparam int IDX_W = $clog2(MAX_WIDTH * 4);
	localparam int Q_W = IDX_W + $bits(item_flags_t);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	logic [IDX_W-1:0] push_idx;
	item_flags_t push_flags;
	logic [Q_W-1:0] q_dout;
	logic [IDX_W-1:0] pop_idx;
	item_flags_t pop_flags;

	puf_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_stream(in_stream),
		.q_full(q_full),
		.q_push(q_push),
		.q_idx(push_idx),
		.q_flags(push_flags)
	);

	puf_queue #(
		.DATA_W(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din({push_idx, push_flags}),
		.full(q_full),
		.pop(q_pop),
		.dout(q_dout),
		.empty(q_empty)
	);

	assign pop_idx = q_dout[Q_W-1 -: IDX_W];
	assign pop_flags = item_flags_t'(q_dout[$bits(item_flags_t)-1:0]);

	puf_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_idx(pop_idx),
		.q_flags(pop_flags),
		.q_pop(q_pop),
		.out_stream(out_stream)
	);

endmodule

FILE: sv/puf_checker.sv
// Port-level assertions for the PNG scanline unfilter and their binding to the top level.
module puf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic last_in_row,
	input logic last_in_image,
	input logic bad_filter
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output item withdrawn while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last_in_row)
			&& $stable(last_in_image) && $stable(bad_filter))
		else $error("Output item changed while stalled.");

	a_image_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_image |-> last_in_row)
		else $error("Image end flagged on a byte that does not end a row.");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled although the output register is empty.");

endmodule

bind png_scanline_unfilter_core puf_checker u_puf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_stream.ready),
	.out_valid(out_stream.valid),
	.out_ready(out_stream.ready),
	.out_byte(out_stream.out_byte),
	.last_in_row(out_stream.last_in_row),
	.last_in_image(out_stream.last_in_image),
	.bad_filter(out_stream.bad_filter)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the PNG scanline unfilter: random byte streams, predicted output.
`timescale 1ns / 1ps

module tb_top;
	import puf_pkg::*;

	localparam int unsigned MAX_W = MAX_WIDTH_DEF;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * 4;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic [7:0] data;
		logic row_end;
		logic img_end;
		logic bad;
	} recon_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	puf_in_if in_if ();
	puf_out_if out_if ();

	png_scanline_unfilter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_stream(in_if),
		.out_stream(out_if)
	);

	logic [7:0] stream_bytes[$];
	recon_t recon_due[$];
	int unsigned queued_total;
	int unsigned taken_total;
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	logic [11:0] cfg_width;
	logic [15:0] cfg_height;
	logic cfg_alpha;

	logic [7:0] above_row[STORE_DEPTH];
	logic [7:0] left_px[4];
	logic [7:0] diag_px[4];
	int unsigned byte_idx;
	logic [15:0] row_num;
	filter_t cur_filter;
	logic cur_raw;

	function automatic int unsigned row_bytes();
		int unsigned w;
		w = (cfg_width == 0) ? 1 : cfg_width;
		if (w > MAX_W)
			w = MAX_W;
		return w * (cfg_alpha ? 4 : 3);
	endfunction

	function automatic int unsigned rows_per_image();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		int p;
		int pa;
		int pb;
		int pc;
		p = int'(a) + int'(b) - int'(c);
		pa = p - int'(a);
		pb = p - int'(b);
		pc = p - int'(c);
		if (pa < 0)
			pa = -pa;
		if (pb < 0)
			pb = -pb;
		if (pc < 0)
			pc = -pc;
		if (pa <= pb && pa <= pc)
			return a;
		if (pb <= pc)
			return b;
		return c;
	endfunction

	function automatic void unfilter_byte(input logic [7:0] x);
		int unsigned bpp;
		int unsigned len;
		int unsigned i;
		int unsigned ch;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] pred;
		logic [7:0] res;
		logic row_end;
		logic img_end;
		recon_t r;
		bpp = cfg_alpha ? 4 : 3;
		len = row_bytes();
		if (byte_idx == 0) begin
			cur_raw = (x > 8'(FILT_PAETH));
			cur_filter = cur_raw ? FILT_NONE : filter_t'(x[2:0]);
			for (int k = 0; k < 4; k++) begin
				left_px[k] = 8'd0;
				diag_px[k] = 8'd0;
			end
			byte_idx = 1;
		end else begin
			i = byte_idx - 1;
			if (i >= STORE_DEPTH)
				i = STORE_DEPTH - 1;
			ch = i % bpp;
			a = left_px[ch];
			b = (row_num == 0) ? 8'd0 : above_row[i];
			c = diag_px[ch];
			case (cur_filter)
				FILT_SUB: pred = a;
				FILT_UP: pred = b;
				FILT_AVG: pred = 8'((16'(a) + 16'(b)) >> 1);
				FILT_PAETH: pred = paeth_pick(a, b, c);
				default: pred = 8'd0;
			endcase
			res = x + pred;
			diag_px[ch] = b;
			left_px[ch] = res;
			above_row[i] = res;
			row_end = (i >= len - 1);
			img_end = row_end && (row_num >= rows_per_image() - 1);
			if (row_end) begin
				byte_idx = 0;
				row_num = img_end ? 16'd0 : row_num + 16'd1;
			end else begin
				byte_idx = i + 2;
			end
			r.data = res;
			r.row_end = row_end;
			r.img_end = img_end;
			r.bad = cur_raw;
			recon_due = {recon_due, r};
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		stream_bytes = {stream_bytes, b};
		queued_total++;
	endfunction

	function automatic void push_row(input logic [7:0] filt);
		int unsigned n;
		n = row_bytes();
		push_byte(filt);
		repeat (n) push_byte(8'($urandom));
	endfunction

	function automatic logic [7:0] pick_filter();
		if ($urandom_range(99) < 10)
			return 8'($urandom_range(255, int'(FILT_PAETH) + 1));
		return 8'($urandom_range(int'(FILT_PAETH)));
	endfunction

	function automatic void push_image();
		repeat (rows_per_image()) push_row(pick_filter());
	endfunction

	task automatic wait_drained();
		while (taken_total != queued_total || recon_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH: cfg_width = val[11:0];
			CFG_IMAGE_HEIGHT: cfg_height = val[15:0];
			CFG_HAS_ALPHA: cfg_alpha = val[0];
			default: ;
		endcase
	endtask

	task automatic report_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		err_count++;
		$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fork
			forever #2 clk = ~clk;
			begin
				repeat (5) @(posedge clk);
				arst_n <= 1'b1;
			end
		join
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.in_byte <= 8'd0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				unfilter_byte(in_if.in_byte);
				taken_total++;
			end
			if (in_if.valid && !in_if.ready) begin
				in_if.valid <= 1'b1;
			end else if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_if.valid <= 1'b1;
				in_if.in_byte <= stream_bytes.pop_front();
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		recon_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (recon_due.size() == 0) begin
					report_field("unexpected out_byte", 8'd0, out_if.out_byte);
				end else begin
					want = recon_due.pop_front();
					if (out_if.out_byte !== want.data)
						report_field("out_byte", want.data, out_if.out_byte);
					if (out_if.last_in_row !== want.row_end)
						report_field("last_in_row", 8'(want.row_end), 8'(out_if.last_in_row));
					if (out_if.last_in_image !== want.img_end)
						report_field("last_in_image", 8'(want.img_end),
							8'(out_if.last_in_image));
					if (out_if.bad_filter !== want.bad)
						report_field("bad_filter", 8'(want.bad), 8'(out_if.bad_filter));
				end
			end
			out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int unsigned start_count;
		int unsigned rand_items;
		int unsigned roll;
		int unsigned w;
		int unsigned h;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		cfg_width = 12'd1;
		cfg_height = 16'd1;
		cfg_alpha = 1'b1;
		for (int k = 0; k < STORE_DEPTH; k++)
			above_row[k] = 8'd0;
		for (int k = 0; k < 4; k++) begin
			left_px[k] = 8'd0;
			diag_px[k] = 8'd0;
		end
		byte_idx = 0;
		row_num = 16'd0;
		cur_filter = FILT_NONE;
		cur_raw = 1'b0;
		queued_total = 0;
		taken_total = 0;
		err_count = 0;
		cycle_count = 0;
		send_idle_pct = 36;
		recv_idle_pct = 72;

		wait (arst_n === 1'b1);
		@(posedge clk);

		push_byte(8'(FILT_NONE));
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		wait_drained();

		write_reg(CFG_IMAGE_WIDTH, 16'd2);
		write_reg(CFG_IMAGE_HEIGHT, 16'd3);
		write_reg(CFG_HAS_ALPHA, 16'd0);
		push_row(8'(FILT_SUB));
		push_row(8'(FILT_AVG));
		push_row(8'(FILT_PAETH));
		wait_drained();

		// A zero width or height counts as one; filter types above Paeth pass raw.
		write_reg(CFG_IMAGE_WIDTH, 16'd0);
		write_reg(CFG_IMAGE_HEIGHT, 16'd0);
		push_row(8'hFF);
		push_row(8'h05);
		wait_drained();

		// Shrinking the registers mid-image ends the image early.
		write_reg(CFG_IMAGE_WIDTH, 16'd2);
		write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
		write_reg(CFG_HAS_ALPHA, 16'd1);
		push_row(8'(FILT_UP));
		push_row(8'(FILT_PAETH));
		wait_drained();
		write_reg(CFG_IMAGE_HEIGHT, 16'd2);
		write_reg(CFG_IMAGE_WIDTH, 16'd1);
		write_reg(CFG_HAS_ALPHA, 16'd0);
		push_row(8'(FILT_AVG));
		wait_drained();

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 72;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 72;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			roll = $urandom_range(99);
			if (roll < 5)
				w = 0;
			else if (roll < 15)
				w = $urandom_range(64, 7);
			else
				w = $urandom_range(6, 1);
			roll = $urandom_range(99);
			if (roll < 10)
				h = 0;
			else if (roll < 15)
				h = $urandom_range(8, 5);
			else
				h = $urandom_range(4, 1);
			write_reg(CFG_HAS_ALPHA, 16'($urandom_range(1)));
			write_reg(CFG_IMAGE_WIDTH, 16'(w));
			write_reg(CFG_IMAGE_HEIGHT, 16'(h));
			start_count = queued_total;
			repeat ($urandom_range(3, 1)) push_image();
			rand_items += queued_total - start_count;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/puf_pkg.sv
sv/puf_if.sv
sv/puf_front.sv
sv/puf_queue.sv
sv/puf_back.sv
sv/png_scanline_unfilter_core.sv
sv/puf_checker.sv
sim/tb_top.sv
